// File: rtl/core/dq_pkg.sv
// shared types, constants and ring helpers for the double-ended queue
`default_nettype none
package dq_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int OPC_W      = 3;
    localparam int VAL_W      = 32;
    localparam int OUT_DATA_W = 40;

    // opcode encodings on the input channel
    localparam logic [OPC_W-1:0] OPC_PUSH_BACK  = 3'd0;
    localparam logic [OPC_W-1:0] OPC_PUSH_FRONT = 3'd1;
    localparam logic [OPC_W-1:0] OPC_LIST       = 3'd2;
    localparam logic [OPC_W-1:0] OPC_POP_BACK   = 3'd3;
    localparam logic [OPC_W-1:0] OPC_POP_FRONT  = 3'd4;

    // decoded operation kind
    typedef enum logic [2:0] {
        OPK_PUSH_BACK,
        OPK_PUSH_FRONT,
        OPK_LIST,
        OPK_POP_BACK,
        OPK_POP_FRONT,
        OPK_NOP
    } op_kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // execution unit states
    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

    // classified command passed from front to back
    typedef struct packed {
        op_kind_t               op;
        logic [DATA_WIDTH-1:0]  value;
    } cmd_t;

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] i);
        if (i == IDX_W'(CAPACITY - 1)) begin
            return '0;
        end
        return i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] i);
        if (i == '0) begin
            return IDX_W'(CAPACITY - 1);
        end
        return i - 1'b1;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/dq_front.sv
// front end: accepts operations, decodes them and queues them for execution
`default_nettype none
module dq_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [31:0]                   s_axis_tdata,   // [31:0] value
    input  wire logic [7:0]                    s_axis_tuser,   // [2:0] opcode
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output dq_pkg::cmd_t                       cmd
);
    import dq_pkg::*;

    cmd_t        q_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;
    cmd_t        decoded;

    // classify the incoming opcode
    always_comb begin
        decoded.value = DATA_WIDTH'(s_axis_tdata);
        case (s_axis_tuser[OPC_W-1:0])
            OPC_PUSH_BACK:  decoded.op = OPK_PUSH_BACK;
            OPC_PUSH_FRONT: decoded.op = OPK_PUSH_FRONT;
            OPC_LIST:       decoded.op = OPK_LIST;
            OPC_POP_BACK:   decoded.op = OPK_POP_BACK;
            OPC_POP_FRONT:  decoded.op = OPK_POP_FRONT;
            default:        decoded.op = OPK_NOP;
        endcase
    end

    // two-entry command queue control
    always_comb begin
        s_axis_tready = (cnt_reg != 2'd2);
        cmd_valid     = (cnt_reg != 2'd0);
        push          = s_axis_tvalid && s_axis_tready;
        pop           = cmd_valid && cmd_ready;
        wr_ptr_next   = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next   = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next      = cnt_reg + {1'b0, push} - {1'b0, pop};
        cmd           = q_mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= decoded;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/dq_back.sv
// back end: ring store, pointers and result register
`default_nettype none
module dq_back (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cmd_valid,
    output logic                                  cmd_ready,
    input  wire dq_pkg::cmd_t                     cmd,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [dq_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // [31:0] data, [36:32] occupancy
    output logic [1:0]                            m_axis_tuser,  // [1:0] status
    output logic                                  m_axis_tlast
);
    import dq_pkg::*;

    logic [DATA_WIDTH-1:0] store_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] back_reg, back_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] remain_reg, remain_next;

    logic             m_valid_reg;
    status_t          m_status_reg;
    logic [31:0]      m_data_reg;
    logic [CNT_W-1:0] m_occ_reg;
    logic             m_last_reg;

    logic             out_free, out_load, out_last;
    status_t          out_status;
    logic [31:0]      out_data;
    logic [CNT_W-1:0] out_occ;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic             full, empty;

    // next state, store access and result selection
    always_comb begin
        out_free    = !m_valid_reg || m_axis_tready;
        full        = (count_reg == CNT_W'(CAPACITY));
        empty       = (count_reg == '0);
        state_next  = state_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        slot_next   = slot_reg;
        remain_next = remain_reg;
        cmd_ready   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = back_reg;
        rd_en       = 1'b0;
        rd_addr     = front_reg;
        out_load    = 1'b0;
        out_status  = ST_OK;
        out_data    = '0;
        out_occ     = count_reg;
        out_last    = 1'b1;
        case (state_reg)
            BK_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready = 1'b1;
                    case (cmd.op)
                        OPK_PUSH_BACK, OPK_PUSH_FRONT: begin
                            out_load = 1'b1;
                            if (full) begin
                                out_status = ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                out_occ    = count_next;
                                if (cmd.op == OPK_PUSH_BACK) begin
                                    wr_addr   = back_reg;
                                    back_next = ring_inc(back_reg);
                                end else begin
                                    wr_addr    = ring_dec(front_reg);
                                    front_next = wr_addr;
                                end
                            end
                        end
                        OPK_POP_BACK, OPK_POP_FRONT, OPK_LIST: begin
                            if (empty) begin
                                out_load   = 1'b1;
                                out_status = ST_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                state_next = BK_EMIT;
                                if (cmd.op == OPK_POP_BACK) begin
                                    rd_addr     = ring_dec(back_reg);
                                    back_next   = rd_addr;
                                    count_next  = count_reg - 1'b1;
                                    remain_next = CNT_W'(1);
                                end else if (cmd.op == OPK_POP_FRONT) begin
                                    rd_addr     = front_reg;
                                    front_next  = ring_inc(front_reg);
                                    count_next  = count_reg - 1'b1;
                                    remain_next = CNT_W'(1);
                                end else begin
                                    rd_addr     = front_reg;
                                    slot_next   = ring_inc(front_reg);
                                    remain_next = count_reg;
                                end
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            BK_EMIT: begin
                // hand out the entry held in the read register, fetch the next one for a list
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = 32'(rd_data_reg);
                    out_last = (remain_reg == CNT_W'(1));
                    if (remain_reg == CNT_W'(1)) begin
                        state_next = BK_IDLE;
                    end else begin
                        rd_en       = 1'b1;
                        rd_addr     = slot_reg;
                        slot_next   = ring_inc(slot_reg);
                        remain_next = remain_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            front_reg   <= '0;
            back_reg    <= '0;
            count_reg   <= '0;
            slot_reg    <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            back_reg    <= back_next;
            count_reg   <= count_next;
            slot_reg    <= slot_next;
            remain_reg  <= remain_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= out_status;
            m_data_reg   <= out_data;
            m_occ_reg    <= out_occ;
            m_last_reg   <= out_last;
        end
    end

    // ring store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= cmd.value;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_occ_reg, m_data_reg};
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule
`default_nettype wire

// File: rtl/core/double_ended_queue.sv
// top level of the bounded double-ended queue
// A 16-entry double-ended queue of signed 32-bit values. Each input transaction is one
// operation (push back, push front, list, pop back, pop front); each produces one result
// transaction, except a list of a non-empty queue, which produces one result per held entry
// from front to back with tlast on the final one. The front end buffers up to two
// operations, so input transactions are taken while a result waits at the output. A push,
// a refused push, an empty pop or list and an unused opcode retire from the idle state; a
// pop or list reads the entry store through its single read port and hands out the
// registered read data from the emit state, which a stall on the result channel holds.
// The entry store has no reset; only held entries are ever read.
`default_nettype none
module double_ended_queue (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [31:0]                  s_axis_tdata,   // [31:0] value
    input  wire logic [7:0]                   s_axis_tuser,   // [2:0] opcode
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [dq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // [31:0] data, [36:32] occupancy
    output logic [1:0]                        m_axis_tuser,   // [1:0] status
    output logic                              m_axis_tlast
);
    import dq_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // decode and buffer operations
    dq_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    // execute against the ring store
    dq_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// File: rtl/core/dq_checker.sv
// port-level checks for the double-ended queue and their bind
`default_nettype none
module dq_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_axis_tvalid,
    input wire logic                         s_axis_tready,
    input wire logic [31:0]                  s_axis_tdata,
    input wire logic [7:0]                   s_axis_tuser,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [dq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [1:0]                   m_axis_tuser,
    input wire logic                         m_axis_tlast
);
    import dq_pkg::*;

    logic [CNT_W-1:0] occ;
    assign occ = m_axis_tdata[32 +: CNT_W];

    // occupancy never exceeds the capacity
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> occ <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    // a full status comes only with a full store, no data and a final marker
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == ST_FULL) |->
            (occ == CNT_W'(CAPACITY) && m_axis_tdata[31:0] == '0 && m_axis_tlast))
        else $error("bad full result");

    // an empty status comes only with an empty store, no data and a final marker
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |->
            (occ == '0 && m_axis_tdata[31:0] == '0 && m_axis_tlast))
        else $error("bad empty result");

    // results within one list keep the same occupancy
    a_list_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (!m_axis_tvalid || occ == $past(occ)))
        else $error("occupancy changed within a list");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
`default_nettype wire
